@@ hdl/tcm_pkg.sv @@
// Shared types, codes and constants of the trajectory condition monitor.
`default_nettype none
package tcm_pkg;

	localparam int DIMENSION_DEF = 8;
	localparam int QUEUE_DEPTH = 2;

	// Input commands.
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_SAMPLE = 2'd2;

	// Result status codes.
	localparam logic [2:0] STATUS_RUNNING = 3'd0;
	localparam logic [2:0] STATUS_MET = 3'd1;
	localparam logic [2:0] STATUS_DIVERGED = 3'd2;
	localparam logic [2:0] STATUS_SETTLED = 3'd3;
	localparam logic [2:0] STATUS_INITIAL = 3'd4;

	// Condition kinds.
	localparam logic [2:0] KIND_FIXED = 3'd0;
	localparam logic [2:0] KIND_POINT = 3'd1;
	localparam logic [2:0] KIND_LEAVE_RECT = 3'd2;
	localparam logic [2:0] KIND_LEAVE_CIRCLE = 3'd3;
	localparam logic [2:0] KIND_IN_RECT = 3'd4;

	// Register indexes.
	localparam logic [1:0] REG_KIND = 2'd0;
	localparam logic [1:0] REG_PRECISION = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_LIMIT = 2'd3;

	// Partial flag bits.
	localparam int FLAG_FIXED = 0;
	localparam int FLAG_POINT = 1;
	localparam int FLAG_RECT = 2;
	localparam int FLAG_DIVERGED = 3;

	localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;
	localparam logic [47:0] PATH_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] index;
		logic signed [31:0] component_value;
		logic signed [31:0] upper_value;
		logic last;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] step_count;
		logic [47:0] path_length;
	} result_t;

	typedef struct packed {
		logic [2:0] condition_kind;
		logic [30:0] precision;
		logic [62:0] radius_squared;
		logic [30:0] overflow_limit;
	} cfg_t;

endpackage
`default_nettype wire

@@ hdl/tcm_front.sv @@
// Front end: accepts input items into a short queue for the back end.
`default_nettype none
module tcm_front import tcm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire item_t in_item,
	output logic head_valid,
	output item_t head_item,
	input wire logic take
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic do_push, do_take;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_take = take && head_valid;

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_take) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_take) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_take) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ hdl/tcm_back.sv @@
// Back end: carries out queued items, tracks the run and holds the result.
`default_nettype none
module tcm_back import tcm_pkg::*; #(
	parameter int DIMENSION = DIMENSION_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire logic head_valid,
	input wire item_t head_item,
	output logic take,
	output logic res_valid,
	output result_t res,
	input wire logic pop
);
	localparam int IW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIFF = 7'b0000010,
		ST_SQP = 7'b0000100,
		ST_SQR = 7'b0001000,
		ST_ACC = 7'b0010000,
		ST_SQRT = 7'b0100000,
		ST_FIN = 7'b1000000
	} state_t;

	state_t state_q;
	logic signed [31:0] prev_q [DIMENSION];
	logic signed [31:0] ref_lo_q [DIMENSION];
	logic signed [31:0] ref_hi_q [DIMENSION];

	item_t item_q;
	logic [IW-1:0] idx;
	logic in_range, head_in_range;
	logic [31:0] dp_q, dr_q;
	logic [63:0] prod_q;
	logic [63:0] step_sum_q, circle_sum_q;
	logic [3:0] flags_q;
	logic settled_q, have_init_q;
	logic [31:0] step_q;
	logic [47:0] path_q;
	logic [63:0] v_q, r_q;
	logic [4:0] sq_cnt_q;
	logic [2:0] status_q;
	logic res_valid_q;
	result_t res_q;

	logic signed [32:0] d_prev, d_ref;
	logic [31:0] dp, dr, mag_x;
	logic [63:0] sq_bit, sq_trial;
	logic [64:0] acc_sum;
	logic [48:0] path_sum;
	logic cond_met;
	logic [2:0] fin_status;

	assign idx = item_q.index[IW-1:0];
	assign in_range = ({1'b0, item_q.index} < 7'(DIMENSION));
	assign head_in_range = ({1'b0, head_item.index} < 7'(DIMENSION));
	assign take = (state_q == ST_IDLE) && head_valid;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// Component differences and magnitudes.
	always_comb begin
		d_prev = {item_q.component_value[31], item_q.component_value} -
			{prev_q[idx][31], prev_q[idx]};
		d_ref = {item_q.component_value[31], item_q.component_value} -
			{ref_lo_q[idx][31], ref_lo_q[idx]};
		dp = d_prev[32] ? 32'(-d_prev) : d_prev[31:0];
		dr = d_ref[32] ? 32'(-d_ref) : d_ref[31:0];
		mag_x = item_q.component_value[31] ? 32'(-item_q.component_value) :
			item_q.component_value;
	end

	// Square root step and saturating sums.
	always_comb begin
		sq_bit = 64'd1 << {sq_cnt_q, 1'b0};
		sq_trial = r_q + sq_bit;
		acc_sum = {1'b0, (state_q == ST_SQR) ? step_sum_q : circle_sum_q} + {1'b0, prod_q};
		path_sum = {1'b0, path_q} + {17'd0, r_q[31:0]};
	end

	// Condition test and status at the close of a vector.
	always_comb begin
		case (cfg.condition_kind)
			KIND_FIXED: cond_met = !flags_q[FLAG_FIXED];
			KIND_POINT: cond_met = !flags_q[FLAG_POINT];
			KIND_LEAVE_RECT: cond_met = flags_q[FLAG_RECT];
			KIND_LEAVE_CIRCLE: cond_met = circle_sum_q > {1'b0, cfg.radius_squared};
			KIND_IN_RECT: cond_met = !flags_q[FLAG_RECT];
			default: cond_met = 1'b0;
		endcase
		if (settled_q) begin
			fin_status = STATUS_SETTLED;
		end else if (flags_q[FLAG_DIVERGED]) begin
			fin_status = STATUS_DIVERGED;
		end else if (cond_met) begin
			fin_status = STATUS_MET;
		end else begin
			fin_status = STATUS_RUNNING;
		end
	end

	// Component and reference storage, and datapath registers.
	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= head_item;
			if (head_item.command == CMD_LOAD && head_in_range) begin
				ref_lo_q[head_item.index[IW-1:0]] <= head_item.component_value;
				ref_hi_q[head_item.index[IW-1:0]] <= head_item.upper_value;
			end
		end
		if (state_q == ST_DIFF) begin
			dp_q <= dp;
			dr_q <= dr;
			prev_q[idx] <= item_q.component_value;
		end
		if (state_q == ST_SQP) begin
			prod_q <= 64'(dp_q) * 64'(dp_q);
		end
		if (state_q == ST_SQR) begin
			prod_q <= 64'(dr_q) * 64'(dr_q);
		end
		// The result carries the updated path and the final status of the vector, or INITIAL and the unchanged path.
		if (state_q == ST_FIN && (!res_valid_q || pop)) begin
			res_q.step_count <= step_q;
			if (status_q == STATUS_INITIAL) begin
				res_q.status <= STATUS_INITIAL;
				res_q.path_length <= path_q;
			end else begin
				res_q.status <= fin_status;
				res_q.path_length <= path_sum[48] ? PATH_MAX : path_sum[47:0];
			end
		end
	end

	// Sequencer and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_sum_q <= '0;
			circle_sum_q <= '0;
			flags_q <= '0;
			settled_q <= 1'b0;
			have_init_q <= 1'b0;
			step_q <= '0;
			path_q <= '0;
			v_q <= '0;
			r_q <= '0;
			sq_cnt_q <= '0;
			status_q <= STATUS_RUNNING;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!res_valid_q || pop)) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (head_item.command == CMD_START) begin
							step_sum_q <= '0;
							circle_sum_q <= '0;
							flags_q <= '0;
							settled_q <= 1'b0;
							have_init_q <= 1'b0;
							step_q <= '0;
							path_q <= '0;
						end else if (head_item.command == CMD_SAMPLE) begin
							state_q <= head_in_range ? ST_DIFF :
								(head_item.last ? ST_ACC : ST_IDLE);
						end
					end
				end
				ST_DIFF: begin
					if (have_init_q) begin
						if (dp > {1'b0, cfg.precision}) flags_q[FLAG_FIXED] <= 1'b1;
						if (dr > {1'b0, cfg.precision}) flags_q[FLAG_POINT] <= 1'b1;
						if (item_q.component_value < ref_lo_q[idx] ||
							item_q.component_value > ref_hi_q[idx]) begin
							flags_q[FLAG_RECT] <= 1'b1;
						end
						if (mag_x >= {1'b0, cfg.overflow_limit}) begin
							flags_q[FLAG_DIVERGED] <= 1'b1;
						end
						state_q <= ST_SQP;
					end else begin
						state_q <= item_q.last ? ST_ACC : ST_IDLE;
					end
				end
				ST_SQP: state_q <= ST_SQR;
				ST_SQR: begin
					step_sum_q <= acc_sum[64] ? '1 : acc_sum[63:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// Entered after the last squares, or directly to close a vector.
					if (have_init_q && in_range) begin
						circle_sum_q <= acc_sum[64] ? '1 : acc_sum[63:0];
					end
					if (!item_q.last) begin
						state_q <= ST_IDLE;
					end else if (!have_init_q) begin
						have_init_q <= 1'b1;
						status_q <= STATUS_INITIAL;
						step_sum_q <= '0;
						circle_sum_q <= '0;
						flags_q <= '0;
						state_q <= ST_FIN;
					end else begin
						if (step_q != STEP_MAX) step_q <= step_q + 1'b1;
						v_q <= step_sum_q;
						r_q <= '0;
						sq_cnt_q <= 5'd31;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					// One digit pair of the root per cycle.
					if (v_q >= sq_trial) begin
						v_q <= v_q - sq_trial;
						r_q <= (r_q >> 1) + sq_bit;
					end else begin
						r_q <= r_q >> 1;
					end
					if (sq_cnt_q == '0) begin
						state_q <= ST_FIN;
						status_q <= STATUS_RUNNING;
					end else begin
						sq_cnt_q <= sq_cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || pop) begin
						if (status_q != STATUS_INITIAL) begin
							path_q <= path_sum[48] ? PATH_MAX : path_sum[47:0];
							if (fin_status == STATUS_MET || fin_status == STATUS_DIVERGED) begin
								settled_q <= 1'b1;
							end
							step_sum_q <= '0;
							circle_sum_q <= '0;
							flags_q <= '0;
							status_q <= fin_status;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/trajectory_condition_monitor.sv @@
// Top level of the trajectory condition monitor.
// Usage: input items (command, index, component_value, upper_value, last) enter
// through a queue port: an item is taken at a clock edge with push high and
// full low. Results leave through a one-entry result register: while empty is
// low the result (status, step_count, path_length) is on the result ports, and
// it is taken at an edge with pop high. Only a sample item with last set gives
// a result. The user must write registers over reg_write / reg_index / reg_data
// only while the block is idle; the block does not enforce it. A two-entry
// input queue decouples the front from the sequencer in the back end. A sample
// component passes through difference, two 32x32 squares and accumulate;
// closing a later vector adds the bit-pair square root and the final update.
// Components of the initial vector skip the squares, and it closes with no
// root. While the result register is full and pop stays low, the back end
// holds in its final step and the input queue fills, then full rises.
// Reset clears the queues, the run state and the registers to their defaults.
`default_nettype none
module trajectory_condition_monitor import tcm_pkg::*; #(
	parameter int DIMENSION = DIMENSION_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [1:0] command,
	input wire logic [5:0] index,
	input wire logic signed [31:0] component_value,
	input wire logic signed [31:0] upper_value,
	input wire logic last,
	output logic empty,
	input wire logic pop,
	output logic [2:0] status,
	output logic [31:0] step_count,
	output logic [47:0] path_length,
	input wire logic reg_write,
	input wire logic [1:0] reg_index,
	input wire logic [62:0] reg_data
);
	cfg_t cfg_q;
	item_t in_item, head_item;
	logic head_valid, take, res_valid;
	result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.condition_kind <= KIND_FIXED;
			cfg_q.precision <= 31'd1;
			cfg_q.radius_squared <= '0;
			cfg_q.overflow_limit <= '1;
		end else if (reg_write) begin
			case (reg_index)
				REG_KIND: cfg_q.condition_kind <= reg_data[2:0];
				REG_PRECISION: cfg_q.precision <= reg_data[30:0];
				REG_RADIUS: cfg_q.radius_squared <= reg_data;
				REG_LIMIT: cfg_q.overflow_limit <= reg_data[30:0];
				default: cfg_q.condition_kind <= cfg_q.condition_kind;
			endcase
		end
	end

	assign in_item = '{command: command, index: index, component_value: component_value,
		upper_value: upper_value, last: last};

	tcm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.head_valid(head_valid), .head_item(head_item), .take(take)
	);

	tcm_back #(.DIMENSION(DIMENSION)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .head_valid(head_valid),
		.head_item(head_item), .take(take), .res_valid(res_valid), .res(res), .pop(pop)
	);

	assign empty = !res_valid;
	assign status = res.status;
	assign step_count = res.step_count;
	assign path_length = res.path_length;
endmodule
`default_nettype wire
